// File: design/cathw_pkg.sv
`timescale 1ns / 1ps

package cathw_pkg;

  localparam int NUM_SCALES_DEF   = 6;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;

  localparam int SCALE_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int DELAY_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SCALE  = 1'b1;

  localparam logic [SCALE_W-1:0] FIRST_SCALE_RST = 3'd0;
  localparam logic [SCALE_W-1:0] LAST_SCALE_RST  = 3'd5;

  typedef struct packed {
    logic [SCALE_W-1:0] first_scale;
    logic [SCALE_W-1:0] last_scale;
  } cfg_t;

  function automatic logic [DELAY_W-1:0] delay_of(input logic [SCALE_W-1:0] first_scale);
    logic [DELAY_W-1:0] d;
    unique case (first_scale)
      3'd0:    d = 4'd0;
      3'd1:    d = 4'd0;
      3'd2:    d = 4'd1;
      3'd3:    d = 4'd3;
      3'd4:    d = 4'd7;
      default: d = 4'd15;
    endcase
    return d;
  endfunction

endpackage

// File: design/cathw_cell.sv
`timescale 1ns / 1ps

module cathw_cell #(
  parameter int LEVEL = 0,
  parameter int DW    = 24,
  parameter int CW    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cathw_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] in_smooth,
  input  logic signed [DW-1:0] in_first,
  input  logic        [CW-1:0] in_count,
  input  logic signed [DW-1:0] in_cap_f,
  input  logic signed [DW-1:0] in_cap_l,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_smooth,
  output logic signed [DW-1:0] out_first,
  output logic        [CW-1:0] out_count,
  output logic signed [DW-1:0] out_cap_f,
  output logic signed [DW-1:0] out_cap_l
);

  localparam int LAG = 2 ** LEVEL;
  localparam logic [CW-1:0] LAG_C = CW'(LAG);

  logic signed [DW-1:0] hist_r [LAG];
  logic signed [DW-1:0] past;
  logic signed [DW:0]   sum;
  logic signed [DW-1:0] smooth_nxt;
  logic signed [DW-1:0] cap_f_nxt;
  logic signed [DW-1:0] cap_l_nxt;

  logic                 valid_r;
  logic signed [DW-1:0] smooth_r;
  logic signed [DW-1:0] first_r;
  logic        [CW-1:0] count_r;
  logic signed [DW-1:0] cap_f_r;
  logic signed [DW-1:0] cap_l_r;

  always_comb begin
    past       = (in_count >= LAG_C) ? hist_r[LAG-1] : in_first;
    sum        = {in_smooth[DW-1], in_smooth} + {past[DW-1], past};
    smooth_nxt = sum[DW:1];
    cap_f_nxt  = (32'(cfg.first_scale) == LEVEL + 1) ? smooth_nxt : in_cap_f;
    cap_l_nxt  = (32'(cfg.last_scale) == LEVEL) ? smooth_nxt : in_cap_l;
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      hist_r[0] <= in_smooth;
      for (int i = 1; i < LAG; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smooth_r <= smooth_nxt;
      first_r  <= in_first;
      count_r  <= in_count;
      cap_f_r  <= cap_f_nxt;
      cap_l_r  <= cap_l_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_smooth = smooth_r;
  assign out_first  = first_r;
  assign out_count  = count_r;
  assign out_cap_f  = cap_f_r;
  assign out_cap_l  = cap_l_r;

endmodule

// File: design/cathw_out.sv
`timescale 1ns / 1ps

module cathw_out #(
  parameter int NUM_SCALES = 6,
  parameter int DW         = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  cathw_pkg::cfg_t                   cfg,
  input  logic                              in_valid,
  input  logic signed [DW-1:0]              in_cap_f,
  input  logic signed [DW-1:0]              in_cap_l,
  output logic                              out_valid,
  output logic signed [DW-1:0]              out_approximation,
  output logic signed [DW-1:0]              out_trend,
  output logic                              out_scales_ok,
  output logic [cathw_pkg::DELAY_W-1:0]     out_delay
);

  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

  logic                              ok;
  logic signed [DW:0]                diff;
  logic signed [DW-1:0]              appx_sat;
  logic                              valid_r;
  logic signed [DW-1:0]              appx_r;
  logic signed [DW-1:0]              trend_r;
  logic                              ok_r;
  logic [cathw_pkg::DELAY_W-1:0]     delay_r;

  always_comb begin
    ok   = (cfg.first_scale <= cfg.last_scale) && (32'(cfg.last_scale) < NUM_SCALES);
    diff = {in_cap_f[DW-1], in_cap_f} - {in_cap_l[DW-1], in_cap_l};
    priority if (diff[DW] != diff[DW-1]) begin
      appx_sat = diff[DW] ? MIN_V : MAX_V;
    end else begin
      appx_sat = diff[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r    <= ok;
      appx_r  <= ok ? appx_sat : '0;
      trend_r <= ok ? in_cap_l : '0;
      delay_r <= ok ? cathw_pkg::delay_of(cfg.first_scale) : '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_approximation = appx_r;
  assign out_trend         = trend_r;
  assign out_scales_ok     = ok_r;
  assign out_delay         = delay_r;

endmodule

// File: design/causal_a_trous_haar_wavelet.sv
`timescale 1ns / 1ps

// Causal a trous Haar decomposition of a signed sample stream.
// Input channel: in_valid, in_stall, in_sample; one word per unstalled cycle.
// Result channel: out_valid, out_stall and the result fields; one result word
// leaves for every input word, in order.
// Each cascade level is a cell with its own delay line of 2^j smooth values,
// and the result stage forms the detail sum, the trend and the delay field.
// An accepted word is registered in each cell in turn, then in the result stage;
// throughput is one word per unstalled cycle, as the cell chain advances.
// When the receiver stalls a pending result, the whole chain holds and
// in_stall rises in the same cycle; it falls as soon as the result is taken.
// Configuration writes go through cfg_we, cfg_index and cfg_wdata and should
// only be made while no words are in flight.
// Synchronous reset clears the pipeline valid bits and the sample counter and
// resets the scale registers; the delay lines need no clearing because the
// counter selects the first sample until each line has filled.
module causal_a_trous_haar_wavelet #(
  parameter int NUM_SCALES   = cathw_pkg::NUM_SCALES_DEF,
  parameter int SAMPLE_WIDTH = cathw_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = cathw_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [cathw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cathw_pkg::SCALE_W-1:0]            cfg_wdata,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]           in_sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] out_approximation,
  output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] out_trend,
  output logic                                     out_scales_ok,
  output logic [cathw_pkg::DELAY_W-1:0]            out_delay
);

  localparam int DW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int CW = NUM_SCALES;
  localparam logic [CW-1:0] COUNT_MAX = CW'(2 ** (NUM_SCALES - 1));

  cathw_pkg::cfg_t      cfg_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic signed [DW-1:0] first_r;
  logic signed [DW-1:0] x;
  logic                 en;
  logic                 accept;

  logic                 valid_c  [NUM_SCALES+1];
  logic signed [DW-1:0] smooth_c [NUM_SCALES+1];
  logic signed [DW-1:0] first_c  [NUM_SCALES+1];
  logic        [CW-1:0] count_c  [NUM_SCALES+1];
  logic signed [DW-1:0] cap_f_c  [NUM_SCALES+1];
  logic signed [DW-1:0] cap_l_c  [NUM_SCALES+1];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;
  assign x        = DW'(in_sample) <<< FRAC_BITS;

  always_comb begin
    count_nxt = count_r;
    if (count_r != COUNT_MAX) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_scale <= cathw_pkg::FIRST_SCALE_RST;
      cfg_r.last_scale  <= cathw_pkg::LAST_SCALE_RST;
      count_r           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cathw_pkg::CFG_FIRST_SCALE: cfg_r.first_scale <= cfg_wdata;
          cathw_pkg::CFG_LAST_SCALE:  cfg_r.last_scale  <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count_r == '0) begin
      first_r <= x;
    end
  end

  assign valid_c[0]  = accept;
  assign smooth_c[0] = x;
  assign first_c[0]  = (count_r == '0) ? x : first_r;
  assign count_c[0]  = count_r;
  assign cap_f_c[0]  = x;
  assign cap_l_c[0]  = x;

  for (genvar j = 0; j < NUM_SCALES; j++) begin : g_cell
    cathw_cell #(
      .LEVEL (j),
      .DW    (DW),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .cfg        (cfg_r),
      .in_valid   (valid_c[j]),
      .in_smooth  (smooth_c[j]),
      .in_first   (first_c[j]),
      .in_count   (count_c[j]),
      .in_cap_f   (cap_f_c[j]),
      .in_cap_l   (cap_l_c[j]),
      .out_valid  (valid_c[j+1]),
      .out_smooth (smooth_c[j+1]),
      .out_first  (first_c[j+1]),
      .out_count  (count_c[j+1]),
      .out_cap_f  (cap_f_c[j+1]),
      .out_cap_l  (cap_l_c[j+1])
    );
  end

  cathw_out #(
    .NUM_SCALES (NUM_SCALES),
    .DW         (DW)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .cfg               (cfg_r),
    .in_valid          (valid_c[NUM_SCALES]),
    .in_cap_f          (cap_f_c[NUM_SCALES]),
    .in_cap_l          (cap_l_c[NUM_SCALES]),
    .out_valid         (out_valid),
    .out_approximation (out_approximation),
    .out_trend         (out_trend),
    .out_scales_ok     (out_scales_ok),
    .out_delay         (out_delay)
  );

endmodule

// File: design/cathw_chk.sv
`timescale 1ns / 1ps

module cathw_chk #(
  parameter int DW = cathw_pkg::SAMPLE_WIDTH_DEF + cathw_pkg::FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [DW-1:0]          out_approximation,
  input logic signed [DW-1:0]          out_trend,
  input logic                          out_scales_ok,
  input logic [cathw_pkg::DELAY_W-1:0] out_delay
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending right after reset");

  a_stall_freezes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while the result word is stalled");

  a_bad_scales_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_scales_ok) |->
      (out_approximation == '0 && out_trend == '0 && out_delay == '0))
    else $error("invalid scale pair with nonzero result fields");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_approximation) && $stable(out_trend)))
    else $error("stalled result word changed");

endmodule

bind causal_a_trous_haar_wavelet cathw_chk #(
  .DW (SAMPLE_WIDTH + FRAC_BITS)
) u_cathw_chk (.*);

// File: verif/cathw_checker.sv
`timescale 1ns / 1ps

module cathw_checker
  import cathw_pkg::*;
(
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               cfg_we,
  input  logic [CFG_IDX_W-1:0]                               cfg_index,
  input  logic [SCALE_W-1:0]                                 cfg_wdata,
  input  logic                                               in_valid,
  input  logic                                               in_stall,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]                 in_sample,
  input  logic                                               out_valid,
  input  logic                                               out_stall,
  input  logic signed [SAMPLE_WIDTH_DEF+FRAC_BITS_DEF-1:0]   out_approximation,
  input  logic signed [SAMPLE_WIDTH_DEF+FRAC_BITS_DEF-1:0]   out_trend,
  input  logic                                               out_scales_ok,
  input  logic [DELAY_W-1:0]                                 out_delay,
  output int                                                 error_count,
  output int                                                 pending_count,
  output int                                                 result_count
);

  localparam int LEVELS = NUM_SCALES_DEF;
  localparam int IN_W = SAMPLE_WIDTH_DEF;
  localparam int OUT_W = SAMPLE_WIDTH_DEF + FRAC_BITS_DEF;
  localparam int LINE_DEPTH = (1 << LEVELS) - 1;
  localparam int COUNT_CAP = 1 << (LEVELS - 1);
  localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam int DELAY_CAP = (1 << DELAY_W) - 1;

  typedef struct {
    logic signed [OUT_W-1:0] approximation;
    logic signed [OUT_W-1:0] trend;
    logic                    scales_ok;
    logic [DELAY_W-1:0]      delay;
  } wavelet_word_t;

  longint             smooth_line [LINE_DEPTH];
  longint             first_value;
  int                 samples_seen;
  logic [SCALE_W-1:0] lo_scale;
  logic [SCALE_W-1:0] hi_scale;
  wavelet_word_t      expected_words [$];
  int                 mismatches = 0;
  int                 words_taken = 0;

  function automatic longint clamp_out(input longint v);
    if (v > OUT_MAX) return OUT_MAX;
    if (v < OUT_MIN) return OUT_MIN;
    return v;
  endfunction

  // Runs one sample through the cascade. The detail sum over a range of
  // levels telescopes to the difference of the two bounding smooth values,
  // and the trend reduces to the smooth value just above the range.
  function automatic wavelet_word_t decompose(input logic signed [IN_W-1:0] sample);
    longint        smooth [LEVELS+1];
    longint        older;
    int            lag;
    int            d;
    wavelet_word_t w;
    smooth[0] = longint'(sample) * (longint'(1) << FRAC_BITS_DEF);
    if (samples_seen == 0) first_value = smooth[0];
    for (int j = 0; j < LEVELS; j++) begin
      lag = 1 << j;
      older = (samples_seen >= lag) ? smooth_line[2 * lag - 2] : first_value;
      for (int k = lag - 1; k > 0; k--) smooth_line[lag - 1 + k] = smooth_line[lag - 2 + k];
      smooth_line[lag - 1] = smooth[j];
      smooth[j + 1] = (smooth[j] + older) >>> 1;
    end
    if (samples_seen < COUNT_CAP) samples_seen++;
    w.approximation = '0;
    w.trend = '0;
    w.scales_ok = 1'b0;
    w.delay = '0;
    if (lo_scale <= hi_scale && hi_scale < LEVELS) begin
      w.approximation = OUT_W'(clamp_out(smooth[lo_scale] - smooth[hi_scale + 1]));
      w.trend = OUT_W'(clamp_out(smooth[hi_scale + 1]));
      w.scales_ok = 1'b1;
      if (lo_scale != 0) begin
        d = (1 << (lo_scale - 1)) - 1;
        w.delay = DELAY_W'((d > DELAY_CAP) ? DELAY_CAP : d);
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin
    wavelet_word_t want;
    if (!rst_n) begin
      foreach (smooth_line[i]) smooth_line[i] = 0;
      first_value = 0;
      samples_seen = 0;
      lo_scale = FIRST_SCALE_RST;
      hi_scale = LAST_SCALE_RST;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_SCALE) lo_scale = cfg_wdata;
        else if (cfg_index == CFG_LAST_SCALE) hi_scale = cfg_wdata;
      end
      if (in_valid && in_stall === 1'b0)
        expected_words.insert(expected_words.size(), decompose(in_sample));
      if (out_valid === 1'b1 && !out_stall) begin
        words_taken++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected:", $time,
                     " appx %0d trend %0d ok %0b delay %0d",
                     out_approximation, out_trend, out_scales_ok, out_delay);
        end else begin
          want = expected_words.pop_front();
          if (out_approximation !== want.approximation || out_trend !== want.trend ||
              out_scales_ok !== want.scales_ok || out_delay !== want.delay) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected appx %0d trend %0d ok %0b delay %0d,",
                       $time, want.approximation, want.trend, want.scales_ok, want.delay,
                       " got appx %0d trend %0d ok %0b delay %0d",
                       out_approximation, out_trend, out_scales_ok, out_delay);
          end
        end
      end
    end
    pending_count <= expected_words.size();
    error_count <= mismatches;
    result_count <= words_taken;
  end

endmodule

// File: verif/tb_causal_a_trous_haar_wavelet.sv
`timescale 1ns / 1ps

module tb_causal_a_trous_haar_wavelet;
  import cathw_pkg::*;

  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
  localparam int OUT_W = SAMPLE_WIDTH_DEF + FRAC_BITS_DEF;
  localparam int LATENCY = NUM_SCALES_DEF + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int DIRECTED = 24;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_FIRST_SCALE;
  logic [SCALE_W-1:0]          cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [OUT_W-1:0]     out_approximation;
  logic signed [OUT_W-1:0]     out_trend;
  logic                        out_scales_ok;
  logic [DELAY_W-1:0]          out_delay;

  int errors;
  int pending;
  int results;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int settings_used = 0;

  logic [SCALE_W-1:0] lo_list [PHASES] = '{0, 0, 5, 1, 2, 3, 6, 0, 4, 7};
  logic [SCALE_W-1:0] hi_list [PHASES] = '{5, 0, 5, 3, 4, 2, 7, 7, 5, 7};
  logic signed [SAMPLE_W-1:0] directed_words [DIRECTED] = '{
    SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 0, -1,
    1, -1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
    16'sh5555, 16'shAAAA, 1, 0, -2, 3, SAMPLE_MAX, -1};

  always #5 clk = ~clk;

  causal_a_trous_haar_wavelet dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_approximation(out_approximation),
    .out_trend        (out_trend),
    .out_scales_ok    (out_scales_ok),
    .out_delay        (out_delay)
  );

  cathw_checker wavelet_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_approximation(out_approximation),
    .out_trend        (out_trend),
    .out_scales_ok    (out_scales_ok),
    .out_delay        (out_delay),
    .error_count      (errors),
    .pending_count    (pending),
    .result_count     (results)
  );

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic signed [SAMPLE_W-1:0] s);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic set_scales(input logic [SCALE_W-1:0] lo, input logic [SCALE_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIRST_SCALE;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_LAST_SCALE;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'(int'($urandom_range(16)) - 8);
      3:       return ($urandom_range(1) != 0) ? '1 : '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_word(directed_words[i]);
    drain;

    for (int p = 0; p < PHASES; p++) begin
      set_scales(lo_list[p], hi_list[p]);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      if (p == 4) hold_toggle = ~hold_toggle;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        send_word(random_sample());
        if (p == 6 && i == WORDS_PER_PHASE / 2) drain;
      end
      drain;
    end
    idle_pct = 0;
    stall_pct = 0;

    $display("Sent %0d sample words across %0d scale settings, valid and invalid pairs alike.",
             words_sent, settings_used);
    $display("Checked %0d result words through idle, stall, long hold-off and drain phases.",
             results);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: causal_a_trous_haar_wavelet.f
design/cathw_pkg.sv
design/cathw_cell.sv
design/cathw_out.sv
design/causal_a_trous_haar_wavelet.sv
design/cathw_chk.sv
verif/cathw_checker.sv
verif/tb_causal_a_trous_haar_wavelet.sv
